/* hw/rtl/i2cdmp_pkg.sv */
// ----------------------------------------------------------------------------
// i2cdmp_pkg
// Shared types and constants for the EEPROM bus dump sequencer.
// ----------------------------------------------------------------------------
package i2cdmp_pkg;

    localparam int DEVICE_COUNT_DEF     = 8;
    localparam int BYTES_PER_DEVICE_DEF = 256;

    localparam int SLOTS  = 4;
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [15:0] POLL_LIMIT_RST = 16'd30000;
    localparam logic [7:0]  BASE_ADDR_RST  = 8'hA0;
    localparam logic [7:0]  WORD_ADDR      = 8'h00;

    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_BASE_ADDR  = 1'b1;

    localparam logic [2:0] RC_OK         = 3'd0;
    localparam logic [2:0] RC_NACK_ADDR  = 3'd1;
    localparam logic [2:0] RC_NACK_WORD  = 3'd2;
    localparam logic [2:0] RC_NACK_RADDR = 3'd3;
    localparam logic [2:0] RC_BUS_ERR    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_WORD  = 3'd2,
        PH_RADDR = 3'd3,
        PH_DATA  = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_TX       = 3'd1,
        ACT_PRIME    = 3'd2,
        ACT_LASTRD   = 3'd3,
        ACT_STORE    = 3'd4,
        ACT_STOP     = 3'd5,
        ACT_RESULT   = 3'd6,
        ACT_COMPLETE = 3'd7
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic [2:0] device;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
        logic [2:0] result_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [2:0]              count;
        t_result [SLOTS-1:0]     item;
    } t_batch;

    function automatic t_result mk_result(t_action a, logic [7:0] tx, logic [2:0] dev,
                                          logic [7:0] bidx, logic [7:0] bval,
                                          logic [2:0] code);
        t_result r;
        r.action      = a;
        r.tx_byte     = tx;
        r.device      = dev;
        r.byte_index  = bidx;
        r.byte_value  = bval;
        r.result_code = code;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

/* hw/rtl/i2cdmp_core.sv */
// ----------------------------------------------------------------------------
// i2cdmp_core
// Sequencer state, config registers and per-word result batch generation.
// ----------------------------------------------------------------------------
module i2cdmp_core #(
    parameter int DEVICE_COUNT     = i2cdmp_pkg::DEVICE_COUNT_DEF,
    parameter int BYTES_PER_DEVICE = i2cdmp_pkg::BYTES_PER_DEVICE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_fire,
    input  logic                i_kind,
    input  logic                i_done_flag,
    input  logic                i_ack_flag,
    input  logic                i_bus_error_flag,
    input  logic                i_stop_pending,
    input  logic [7:0]          i_read_data,
    output i2cdmp_pkg::t_batch  o_batch
);

    i2cdmp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_dev, n_dev;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_poll, n_poll;
    logic [2:0]  r_code, n_code;
    logic [15:0] r_poll_limit;
    logic [7:0]  r_base;

    logic [2:0]  cnt;
    logic        timeout;
    logic        bad;
    logic [7:0]  waddr;
    i2cdmp_pkg::t_result [i2cdmp_pkg::SLOTS-1:0] items;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= i2cdmp_pkg::POLL_LIMIT_RST;
            r_base       <= i2cdmp_pkg::BASE_ADDR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cdmp_pkg::CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                i2cdmp_pkg::CFG_BASE_ADDR:  r_base       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_dev   = r_dev;
        n_byte  = r_byte;
        n_poll  = r_poll;
        n_code  = r_code;
        cnt     = 3'd0;
        items   = '0;
        timeout = 1'b0;
        bad     = 1'b0;
        waddr   = 8'd0;
        if (i_fire) begin
            if (!i_kind) begin
                if (r_phase == i2cdmp_pkg::PH_IDLE) begin
                    n_dev  = 3'd0;
                    n_byte = 8'd0;
                    n_code = i2cdmp_pkg::RC_OK;
                    waddr  = r_base;
                    items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_START, 8'd0, 3'd0,
                                                     8'd0, 8'd0, 3'd0);
                    items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_TX, waddr, 3'd0,
                                                     8'd0, 8'd0, 3'd0);
                    cnt     = 3'd2;
                    n_phase = i2cdmp_pkg::PH_ADDR;
                    n_poll  = 16'd0;
                end
            end else if (r_phase != i2cdmp_pkg::PH_IDLE) begin
                n_poll  = r_poll + 16'd1;
                timeout = n_poll >= r_poll_limit;
                bad     = !i_ack_flag || i_bus_error_flag;
                if (r_phase == i2cdmp_pkg::PH_STOP) begin
                    if (!i_stop_pending || timeout) begin
                        items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_RESULT, 8'd0, r_dev,
                                                         8'd0, 8'd0, r_code);
                        n_code = i2cdmp_pkg::RC_OK;
                        if (int'(r_dev) >= DEVICE_COUNT - 1) begin
                            items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_COMPLETE, 8'd0,
                                                             3'd0, 8'd0, 8'd0, 3'd0);
                            cnt     = 3'd2;
                            n_dev   = 3'd0;
                            n_phase = i2cdmp_pkg::PH_IDLE;
                            n_poll  = 16'd0;
                        end else begin
                            n_dev = r_dev + 3'd1;
                            waddr = r_base + {4'b0000, n_dev, 1'b0};
                            items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_START, 8'd0,
                                                             n_dev, 8'd0, 8'd0, 3'd0);
                            items[2] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_TX, waddr,
                                                             n_dev, 8'd0, 8'd0, 3'd0);
                            cnt     = 3'd3;
                            n_phase = i2cdmp_pkg::PH_ADDR;
                            n_poll  = 16'd0;
                        end
                    end
                end else if (i_done_flag || i_bus_error_flag || timeout) begin
                    n_poll = 16'd0;
                    waddr  = r_base + {4'b0000, r_dev, 1'b0};
                    unique case (r_phase)
                        i2cdmp_pkg::PH_ADDR: begin
                            if (bad) begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STOP, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd1;
                                n_code  = i2cdmp_pkg::RC_NACK_ADDR;
                                n_phase = i2cdmp_pkg::PH_STOP;
                            end else begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_TX,
                                                                 i2cdmp_pkg::WORD_ADDR,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd1;
                                n_phase = i2cdmp_pkg::PH_WORD;
                            end
                        end
                        i2cdmp_pkg::PH_WORD: begin
                            if (bad) begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STOP, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd1;
                                n_code  = i2cdmp_pkg::RC_NACK_WORD;
                                n_phase = i2cdmp_pkg::PH_STOP;
                            end else begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_START, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_TX,
                                                                 waddr | 8'h01,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd2;
                                n_phase = i2cdmp_pkg::PH_RADDR;
                            end
                        end
                        i2cdmp_pkg::PH_RADDR: begin
                            if (bad) begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STOP, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd1;
                                n_code  = i2cdmp_pkg::RC_NACK_RADDR;
                                n_phase = i2cdmp_pkg::PH_STOP;
                            end else begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_PRIME, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt    = 3'd1;
                                n_byte = 8'd0;
                                if (BYTES_PER_DEVICE <= 1) begin
                                    items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_LASTRD,
                                                                     8'd0, r_dev, 8'd0, 8'd0,
                                                                     3'd0);
                                    cnt = 3'd2;
                                end
                                n_phase = i2cdmp_pkg::PH_DATA;
                            end
                        end
                        i2cdmp_pkg::PH_DATA: begin
                            if (i_bus_error_flag) begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STOP, 8'd0,
                                                                 r_dev, 8'd0, 8'd0, 3'd0);
                                cnt     = 3'd1;
                                n_code  = i2cdmp_pkg::RC_BUS_ERR;
                                n_phase = i2cdmp_pkg::PH_STOP;
                            end else begin
                                items[0] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STORE, 8'd0,
                                                                 r_dev, r_byte, i_read_data,
                                                                 3'd0);
                                cnt = 3'd1;
                                if (int'(r_byte) + 1 >= BYTES_PER_DEVICE) begin
                                    items[1] = i2cdmp_pkg::mk_result(i2cdmp_pkg::ACT_STOP,
                                                                     8'd0, r_dev, 8'd0, 8'd0,
                                                                     3'd0);
                                    cnt     = 3'd2;
                                    n_code  = i2cdmp_pkg::RC_OK;
                                    n_phase = i2cdmp_pkg::PH_STOP;
                                end else begin
                                    n_byte = r_byte + 8'd1;
                                    if (int'(n_byte) + 1 == BYTES_PER_DEVICE) begin
                                        items[1] = i2cdmp_pkg::mk_result(
                                            i2cdmp_pkg::ACT_LASTRD, 8'd0, r_dev, 8'd0, 8'd0,
                                            3'd0);
                                        cnt = 3'd2;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_phase = i2cdmp_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end
        for (int i = 0; i < i2cdmp_pkg::SLOTS; i++) begin
            items[i].last = (3'(i) + 3'd1 == cnt);
        end
        o_batch.count = cnt;
        o_batch.item  = items;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cdmp_pkg::PH_IDLE;
            r_dev   <= 3'd0;
            r_byte  <= 8'd0;
            r_poll  <= 16'd0;
            r_code  <= i2cdmp_pkg::RC_OK;
        end else begin
            r_phase <= n_phase;
            r_dev   <= n_dev;
            r_byte  <= n_byte;
            r_poll  <= n_poll;
            r_code  <= n_code;
        end
    end

endmodule

/* hw/rtl/i2cdmp_outq.sv */
// ----------------------------------------------------------------------------
// i2cdmp_outq
// Result queue: takes a batch of up to four words per cycle, hands out one while i_ready is high.
// ----------------------------------------------------------------------------
module i2cdmp_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cdmp_pkg::t_batch   i_batch,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cdmp_pkg::t_result  o_head
);

    i2cdmp_pkg::t_result r_mem [i2cdmp_pkg::QDEPTH];
    logic [i2cdmp_pkg::QAW-1:0] r_rd, n_rd;
    logic [i2cdmp_pkg::QAW-1:0] r_wr, n_wr;
    logic [i2cdmp_pkg::QAW:0]   r_cnt, n_cnt;
    logic                       deq;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (int'(r_cnt) <= i2cdmp_pkg::QDEPTH - i2cdmp_pkg::SLOTS);
    assign o_head  = r_mem[r_rd];
    assign deq     = o_valid && i_ready;

    always_comb begin
        n_rd  = r_rd + (i2cdmp_pkg::QAW)'(deq);
        n_wr  = r_wr + (i2cdmp_pkg::QAW)'(i_batch.count);
        n_cnt = r_cnt + (i2cdmp_pkg::QAW + 1)'(i_batch.count)
                - (i2cdmp_pkg::QAW + 1)'(deq);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < i2cdmp_pkg::SLOTS; i++) begin
            if (3'(i) < i_batch.count) begin
                r_mem[r_wr + (i2cdmp_pkg::QAW)'(i)] <= i_batch.item[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hw/rtl/i2c_eeprom_bus_dump_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_bus_dump_sequencer
// Drives a byte-level I2C master through a random read of each EEPROM.
//
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_ready    kind, flags, read_data
// out      out  o_out_valid / i_out_ready  action, tx_byte, device, index, value, code, last
// cfg      in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word is taken per cycle; its state update and up to three result words
// are produced in the same cycle and written into an eight-entry result queue.
// The queue drains one result per cycle while i_out_ready is high; o_in_ready drops
// with fewer than four entries free. Synchronous active-low reset clears state and queue.
// ----------------------------------------------------------------------------
module i2c_eeprom_bus_dump_sequencer #(
    parameter int DEVICE_COUNT     = i2cdmp_pkg::DEVICE_COUNT_DEF,
    parameter int BYTES_PER_DEVICE = i2cdmp_pkg::BYTES_PER_DEVICE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic        i_done_flag,
    input  logic        i_ack_flag,
    input  logic        i_bus_error_flag,
    input  logic        i_stop_pending,
    input  logic [7:0]  i_read_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_tx_byte,
    output logic [2:0]  o_device,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_result_code,
    output logic        o_last
);

    i2cdmp_pkg::t_batch  batch;
    i2cdmp_pkg::t_result head;
    logic                room;

    assign o_in_ready = room;

    i2cdmp_core #(
        .DEVICE_COUNT     (DEVICE_COUNT),
        .BYTES_PER_DEVICE (BYTES_PER_DEVICE)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_fire           (i_in_valid && room),
        .i_kind           (i_kind),
        .i_done_flag      (i_done_flag),
        .i_ack_flag       (i_ack_flag),
        .i_bus_error_flag (i_bus_error_flag),
        .i_stop_pending   (i_stop_pending),
        .i_read_data      (i_read_data),
        .o_batch          (batch)
    );

    i2cdmp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (batch),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    assign o_action      = head.action;
    assign o_tx_byte     = head.tx_byte;
    assign o_device      = head.device;
    assign o_byte_index  = head.byte_index;
    assign o_byte_value  = head.byte_value;
    assign o_result_code = head.result_code;
    assign o_last        = head.last;

endmodule
